[design/rul_pkg.sv]
// Shared types and constants for the resource usage ledger.
// Command and status codes, controller/datapath bundles, default sizes.
// No dependencies.
package rul_pkg;

	localparam int TABLE_DEPTH_DEF = 32;
	localparam int KIND_COUNT_DEF  = 16;
	localparam int OWNER_COUNT_DEF = 16;

	localparam int HANDLE_W = 32;
	localparam int SIZE_W   = 48;
	localparam int BYTES_W  = 56;
	localparam int FRAME_W  = 32;
	localparam int COUNT_W  = 32;
	localparam int WINDOW_W = 8;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 8'd9;

	typedef enum logic [3:0] {
		CMD_REGISTER   = 4'd0,
		CMD_UNREGISTER = 4'd1,
		CMD_RESIZE     = 4'd2,
		CMD_ADVANCE    = 4'd3,
		CMD_SNAPSHOT   = 4'd4,
		CMD_KIND_BYTES = 4'd5,
		CMD_OWNER_BYTES = 4'd6,
		CMD_LEAK_SCAN  = 4'd7,
		CMD_CLEAR      = 4'd8
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_DUP     = 3'd1,
		ST_UNKNOWN = 3'd2,
		ST_FULL    = 3'd3,
		ST_ZERO    = 3'd4
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic prep;
		logic apply;
		logic emit;
	} ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic needs_scan;
		logic scan_done;
	} stat_t;

	// Saturating add of two byte totals.
	function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] a,
			input logic [BYTES_W-1:0] b);
		logic [BYTES_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[BYTES_W] ? {BYTES_W{1'b1}} : s[BYTES_W-1:0];
	endfunction

endpackage

[design/resource_usage_ledger_unit.sv]
// Top level of the resource usage ledger.
// Instantiates rul_ctrl and rul_dp; depends on rul_pkg.
//
// Usage. A command is taken at a rising edge where start is high and busy is
// low; its fields (command, handle, kind, owner, size_bytes, age_threshold)
// are sampled at that edge. Each result beat is shown for exactly one cycle
// with done high, and the receiver cannot hold it off; last marks the final
// beat of a command. Every command gives one beat except a leak scan, which
// gives one beat per old record (at least one).
// Timing. Commands that need no table walk (advance frame, group queries,
// clear, zero handle, unused codes) skip it, the beat appearing in the same
// cycle that busy falls. Register, unregister, resize, snapshot and leak
// scan walk the record table through its single read port, one entry a
// cycle. Leak beats come out during the walk as each later candidate is
// found. The user must write the pending window register over
// cfg_valid/cfg_ready (always ready) only while no command is in flight; the
// block does not enforce this. Reset empties the table, zeroes all counters
// and totals and loads the pending window with nine; no clearing pass is
// needed, as record validity sits in flip-flops.
module resource_usage_ledger_unit #(
	parameter int TABLE_DEPTH = rul_pkg::TABLE_DEPTH_DEF,
	parameter int KIND_COUNT  = rul_pkg::KIND_COUNT_DEF,
	parameter int OWNER_COUNT = rul_pkg::OWNER_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [3:0]                  command,
	input  logic [rul_pkg::HANDLE_W-1:0] handle,
	input  logic [3:0]                  kind,
	input  logic [3:0]                  owner,
	input  logic [rul_pkg::SIZE_W-1:0]   size_bytes,
	input  logic [rul_pkg::FRAME_W-1:0]  age_threshold,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rul_pkg::WINDOW_W-1:0] cfg_data,
	output logic                        done,
	output logic [2:0]                  status,
	output logic [rul_pkg::FRAME_W-1:0]  frame_index,
	output logic [5:0]                  active_count,
	output logic [rul_pkg::BYTES_W-1:0]  current_bytes,
	output logic [rul_pkg::BYTES_W-1:0]  peak_bytes,
	output logic [rul_pkg::COUNT_W-1:0]  created_count,
	output logic [rul_pkg::COUNT_W-1:0]  destroyed_count,
	output logic [5:0]                  pending_count,
	output logic [rul_pkg::BYTES_W-1:0]  group_bytes,
	output logic [rul_pkg::HANDLE_W-1:0] record_handle,
	output logic [3:0]                  record_kind,
	output logic                        last
);
	import rul_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	// The configuration register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	rul_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	rul_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KIND_COUNT  (KIND_COUNT),
		.OWNER_COUNT (OWNER_COUNT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.stat            (stat),
		.command         (command),
		.handle          (handle),
		.kind            (kind),
		.owner           (owner),
		.size_bytes      (size_bytes),
		.age_threshold   (age_threshold),
		.cfg_valid       (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.done            (done),
		.status          (status),
		.frame_index     (frame_index),
		.active_count    (active_count),
		.current_bytes   (current_bytes),
		.peak_bytes      (peak_bytes),
		.created_count   (created_count),
		.destroyed_count (destroyed_count),
		.pending_count   (pending_count),
		.group_bytes     (group_bytes),
		.record_handle   (record_handle),
		.record_kind     (record_kind),
		.last            (last)
	);

`ifndef SYNTHESIS
	a_last_has_done: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> done) else $error("last raised without a result beat");
	a_no_beat_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done && last |=> !done) else $error("beat follows the final beat");
`endif

endmodule

[design/rul_ctrl.sv]
// Controller state machine of the resource usage ledger.
// Depends on rul_pkg for the command and status bundles.
module rul_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  rul_pkg::stat_t stat,
	output rul_pkg::ctrl_t ctrl,
	output logic          busy
);
	import rul_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_PREP  = 5'b00100,
		S_APPLY = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = stat.needs_scan ? S_SCAN : S_APPLY;
			end
			S_SCAN: begin
				if (stat.scan_done) state_d = S_PREP;
			end
			S_PREP:  state_d = S_APPLY;
			S_APPLY: state_d = S_EMIT;
			S_EMIT:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign busy       = (state_q != S_IDLE);
	assign ctrl.load  = (state_q == S_IDLE) && start;
	assign ctrl.scan  = (state_q == S_SCAN);
	assign ctrl.prep  = (state_q == S_PREP);
	assign ctrl.apply = (state_q == S_APPLY);
	assign ctrl.emit  = (state_q == S_EMIT);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted command did not raise busy");
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |=> !busy) else $error("controller did not return to idle");
`endif

endmodule

[design/rul_dp.sv]
// Datapath of the resource usage ledger: record table, totals, scan logic, result registers.
// Depends on rul_pkg; sequenced by rul_ctrl.
module rul_dp #(
	parameter int TABLE_DEPTH = rul_pkg::TABLE_DEPTH_DEF,
	parameter int KIND_COUNT  = rul_pkg::KIND_COUNT_DEF,
	parameter int OWNER_COUNT = rul_pkg::OWNER_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rul_pkg::ctrl_t              ctrl,
	output rul_pkg::stat_t              stat,
	input  logic [3:0]                  command,
	input  logic [rul_pkg::HANDLE_W-1:0] handle,
	input  logic [3:0]                  kind,
	input  logic [3:0]                  owner,
	input  logic [rul_pkg::SIZE_W-1:0]   size_bytes,
	input  logic [rul_pkg::FRAME_W-1:0]  age_threshold,
	input  logic                        cfg_valid,
	input  logic [rul_pkg::WINDOW_W-1:0] cfg_data,
	output logic                        done,
	output logic [2:0]                  status,
	output logic [rul_pkg::FRAME_W-1:0]  frame_index,
	output logic [5:0]                  active_count,
	output logic [rul_pkg::BYTES_W-1:0]  current_bytes,
	output logic [rul_pkg::BYTES_W-1:0]  peak_bytes,
	output logic [rul_pkg::COUNT_W-1:0]  created_count,
	output logic [rul_pkg::COUNT_W-1:0]  destroyed_count,
	output logic [5:0]                  pending_count,
	output logic [rul_pkg::BYTES_W-1:0]  group_bytes,
	output logic [rul_pkg::HANDLE_W-1:0] record_handle,
	output logic [3:0]                  record_kind,
	output logic                        last
);
	import rul_pkg::*;

	localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW  = $clog2(TABLE_DEPTH + 1);
	localparam int KAW = (KIND_COUNT > 1) ? $clog2(KIND_COUNT) : 1;
	localparam int OAW = (OWNER_COUNT > 1) ? $clog2(OWNER_COUNT) : 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

	// Latched command.
	cmd_t                cmd_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [3:0]          kind_q, owner_q;
	logic [SIZE_W-1:0]   size_q;
	logic [FRAME_W-1:0]  thr_q;
	logic [WINDOW_W-1:0] window_q;

	// Record table.
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [HANDLE_W-1:0] m_handle [TABLE_DEPTH];
	logic [3:0]          m_kind   [TABLE_DEPTH];
	logic [3:0]          m_owner  [TABLE_DEPTH];
	logic [SIZE_W-1:0]   m_size   [TABLE_DEPTH];
	logic [FRAME_W-1:0]  m_birth  [TABLE_DEPTH];

	// Ledger counters and group totals.
	logic [FRAME_W-1:0] frame_q;
	logic [BYTES_W-1:0] total_q, peak_q;
	logic [CW-1:0]      live_q;
	logic [COUNT_W-1:0] made_q, freed_q;
	logic [BYTES_W-1:0] kbytes_q [KIND_COUNT];
	logic [BYTES_W-1:0] obytes_q [OWNER_COUNT];

	// Scan pipeline.
	logic [AW-1:0]       idx_q, idx_s1;
	logic                issue_q, sv_s1;
	logic [HANDLE_W-1:0] rd_handle_s1;
	logic [3:0]          rd_kind_s1, rd_owner_s1;
	logic [SIZE_W-1:0]   rd_size_s1;
	logic [FRAME_W-1:0]  rd_birth_s1;

	// Scan findings.
	logic                found_q, free_found_q, cand_v_q;
	logic [AW-1:0]       fslot_q, free_slot_q;
	logic [SIZE_W-1:0]   fsize_q;
	logic [3:0]          fowner_q, cand_k_q;
	logic [HANDLE_W-1:0] cand_h_q;
	logic [CW-1:0]       pend_q;

	// Prepared subtractions.
	logic [BYTES_W-1:0] tsub_q, ksub_q, osub_q, new_q;
	logic               tund_q, kund_q, ound_q;
	logic [3:0]         oidx_q;
	status_t            status_q;

	// Result registers.
	logic                done_q, last_q;
	status_t             r_status_q;
	logic [FRAME_W-1:0]  r_frame_q;
	logic [5:0]          r_active_q, r_pend_q;
	logic [BYTES_W-1:0]  r_total_q, r_peak_q, r_group_q;
	logic [COUNT_W-1:0]  r_made_q, r_freed_q;
	logic [HANDLE_W-1:0] r_handle_q;
	logic [3:0]          r_kind_q;

	// Decoded signals.
	logic               in_zero, in_keyed;
	logic               ev_valid, ev_match, ev_leak, ev_pend;
	logic [FRAME_W-1:0] ev_age;
	logic               emit_mid;
	logic               kind_ok, own_ok, oidx_ok;
	logic [KAW-1:0]     kidx;
	logic [OAW-1:0]     oidx, qidx;
	logic [BYTES_W-1:0] old_v, new_v, kcur, ocur;
	logic               q_zero, do_upd, is_resize;
	logic [AW-1:0]      slot;
	status_t            st_d;
	logic [BYTES_W-1:0] t_new, k_new, o_new, peak_new, group_val;

	assign in_keyed = (command == CMD_REGISTER) || (command == CMD_UNREGISTER) ||
		(command == CMD_RESIZE);
	assign in_zero  = in_keyed && (handle == '0);
	assign stat.needs_scan = (in_keyed && !in_zero) || (command == CMD_SNAPSHOT) ||
		(command == CMD_LEAK_SCAN);
	assign stat.scan_done = sv_s1 && (idx_s1 == LAST_SLOT);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) window_q <= WINDOW_RESET;
		else if (cfg_valid) window_q <= cfg_data;
	end

	// Command latch.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q    <= cmd_t'(command);
			handle_q <= handle;
			kind_q   <= kind;
			owner_q  <= owner;
			size_q   <= size_bytes;
			thr_q    <= age_threshold;
		end
	end

	// Table read, one entry a cycle.
	always_ff @(posedge clk) begin
		rd_handle_s1 <= m_handle[idx_q];
		rd_kind_s1   <= m_kind[idx_q];
		rd_owner_s1  <= m_owner[idx_q];
		rd_size_s1   <= m_size[idx_q];
		rd_birth_s1  <= m_birth[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			issue_q <= 1'b0;
			sv_s1   <= 1'b0;
			idx_s1  <= '0;
		end else begin
			sv_s1  <= ctrl.scan && issue_q;
			idx_s1 <= idx_q;
			if (ctrl.load) begin
				idx_q   <= '0;
				issue_q <= 1'b1;
			end else if (ctrl.scan && issue_q) begin
				if (idx_q == LAST_SLOT) issue_q <= 1'b0;
				else idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Evaluation of the entry read last cycle.
	always_comb begin
		ev_valid = sv_s1 && valid_q[idx_s1];
		ev_match = ev_valid && (rd_handle_s1 == handle_q) && (rd_kind_s1 == kind_q);
		ev_age   = (frame_q >= rd_birth_s1) ? frame_q - rd_birth_s1 : '0;
		ev_pend  = ev_valid && (cmd_q == CMD_SNAPSHOT) &&
			(ev_age < FRAME_W'(window_q));
		ev_leak  = ev_valid && (cmd_q == CMD_LEAK_SCAN) && (frame_q > rd_birth_s1) &&
			((frame_q - rd_birth_s1) >= thr_q);
		emit_mid = ev_leak && cand_v_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			cand_v_q     <= 1'b0;
			pend_q       <= '0;
		end else if (ctrl.load) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			cand_v_q     <= 1'b0;
			pend_q       <= '0;
		end else if (sv_s1) begin
			if (ev_match) found_q <= 1'b1;
			if (!ev_valid && !free_found_q) free_found_q <= 1'b1;
			if (ev_leak) cand_v_q <= 1'b1;
			if (ev_pend) pend_q <= pend_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_match) begin
			fslot_q  <= idx_s1;
			fsize_q  <= rd_size_s1;
			fowner_q <= rd_owner_s1;
		end
		if (sv_s1 && !valid_q[idx_s1] && !free_found_q) free_slot_q <= idx_s1;
		if (ev_leak) begin
			cand_h_q <= rd_handle_s1;
			cand_k_q <= rd_kind_s1;
		end
	end

	// Group indices and the old and new sizes of the record.
	always_comb begin
		is_resize = (cmd_q == CMD_RESIZE);
		kind_ok   = 32'(kind_q) < KIND_COUNT;
		own_ok    = 32'(owner_q) < OWNER_COUNT;
		oidx_ok   = 32'(oidx_q) < OWNER_COUNT;
		kidx      = KAW'(kind_q);
		qidx      = OAW'(owner_q);
		oidx      = OAW'(oidx_q);
		old_v     = (cmd_q == CMD_REGISTER) ? '0 : BYTES_W'(fsize_q);
		new_v     = (cmd_q == CMD_UNREGISTER) ? '0 : BYTES_W'(size_q);
		kcur      = kind_ok ? kbytes_q[kidx] : '0;
		ocur      = obytes_q[OAW'((cmd_q == CMD_REGISTER) ? owner_q : fowner_q)];
	end

	always_ff @(posedge clk) begin
		if (ctrl.prep) begin
			oidx_q <= (cmd_q == CMD_REGISTER) ? owner_q : fowner_q;
			new_q  <= new_v;
			tund_q <= total_q < old_v;
			tsub_q <= (total_q >= old_v) ? total_q - old_v : '0;
			kund_q <= kcur < old_v;
			ksub_q <= (kcur >= old_v) ? kcur - old_v : '0;
			ound_q <= ocur < old_v;
			osub_q <= (ocur >= old_v) ? ocur - old_v : '0;
		end
	end

	// Outcome of the command.
	always_comb begin
		q_zero = ((cmd_q == CMD_REGISTER) || (cmd_q == CMD_UNREGISTER) || is_resize) &&
			(handle_q == '0);
		st_d   = ST_OK;
		do_upd = 1'b0;
		if (q_zero) begin
			st_d = ST_ZERO;
		end else begin
			case (cmd_q)
				CMD_REGISTER: begin
					if (found_q) st_d = ST_DUP;
					else if (!free_found_q) st_d = ST_FULL;
					else do_upd = 1'b1;
				end
				CMD_UNREGISTER: begin
					if (!found_q) st_d = ST_UNKNOWN;
					else do_upd = 1'b1;
				end
				CMD_RESIZE: begin
					if (!found_q) st_d = ST_UNKNOWN;
					else do_upd = (fsize_q != size_q);
				end
				default: st_d = ST_OK;
			endcase
		end
		slot  = (cmd_q == CMD_REGISTER) ? free_slot_q : fslot_q;
		t_new = (tund_q && is_resize) ? new_q : sat_add(tsub_q, new_q);
		k_new = (kund_q && is_resize) ? new_q : sat_add(ksub_q, new_q);
		o_new = (ound_q && is_resize) ? new_q : sat_add(osub_q, new_q);
		peak_new = (total_q > peak_q) ? total_q : peak_q;
		if (cmd_q == CMD_KIND_BYTES) group_val = kind_ok ? kbytes_q[kidx] : '0;
		else if (cmd_q == CMD_OWNER_BYTES) group_val = own_ok ? obytes_q[qidx] : '0;
		else group_val = '0;
	end

	// Table writes.
	always_ff @(posedge clk) begin
		if (ctrl.apply && do_upd) begin
			if (cmd_q == CMD_REGISTER) begin
				m_handle[slot] <= handle_q;
				m_kind[slot]   <= kind_q;
				m_owner[slot]  <= owner_q;
				m_birth[slot]  <= frame_q;
			end
			if (cmd_q != CMD_UNREGISTER) m_size[slot] <= size_q;
		end
	end

	// Ledger state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			frame_q  <= '0;
			total_q  <= '0;
			peak_q   <= '0;
			live_q   <= '0;
			made_q   <= '0;
			freed_q  <= '0;
			status_q <= ST_OK;
			for (int i = 0; i < KIND_COUNT; i++) kbytes_q[i] <= '0;
			for (int i = 0; i < OWNER_COUNT; i++) obytes_q[i] <= '0;
		end else begin
			if (ctrl.apply) begin
				status_q <= st_d;
				if (cmd_q == CMD_CLEAR) begin
					valid_q <= '0;
					frame_q <= '0;
					total_q <= '0;
					peak_q  <= '0;
					live_q  <= '0;
					made_q  <= '0;
					freed_q <= '0;
					for (int i = 0; i < KIND_COUNT; i++) kbytes_q[i] <= '0;
					for (int i = 0; i < OWNER_COUNT; i++) obytes_q[i] <= '0;
				end else if (cmd_q == CMD_ADVANCE) begin
					frame_q <= frame_q + 1'b1;
				end else if (do_upd) begin
					total_q <= t_new;
					if (kind_ok) kbytes_q[kidx] <= k_new;
					if (oidx_ok) obytes_q[oidx] <= o_new;
					if (cmd_q == CMD_REGISTER) begin
						valid_q[slot] <= 1'b1;
						live_q <= live_q + 1'b1;
						if (made_q != '1) made_q <= made_q + 1'b1;
					end else if (cmd_q == CMD_UNREGISTER) begin
						valid_q[slot] <= 1'b0;
						if (live_q != '0) live_q <= live_q - 1'b1;
						if (freed_q != '1) freed_q <= freed_q + 1'b1;
					end
				end
			end
			if (ctrl.emit) peak_q <= peak_new;
		end
	end

	// Result beats.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			done_q <= ctrl.emit || emit_mid;
			last_q <= ctrl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit || emit_mid) begin
			r_status_q <= ctrl.emit ? status_q : ST_OK;
			r_frame_q  <= frame_q;
			r_active_q <= 6'(live_q);
			r_total_q  <= total_q;
			r_peak_q   <= ctrl.emit ? peak_new : peak_q;
			r_made_q   <= made_q;
			r_freed_q  <= freed_q;
			r_pend_q   <= ctrl.emit ? 6'(pend_q) : '0;
			r_group_q  <= ctrl.emit ? group_val : '0;
			if (emit_mid || (cmd_q == CMD_LEAK_SCAN && cand_v_q)) begin
				r_handle_q <= cand_h_q;
				r_kind_q   <= cand_k_q;
			end else begin
				r_handle_q <= '0;
				r_kind_q   <= '0;
			end
		end
	end

	assign done            = done_q;
	assign last            = last_q;
	assign status          = r_status_q;
	assign frame_index     = r_frame_q;
	assign active_count    = r_active_q;
	assign current_bytes   = r_total_q;
	assign peak_bytes      = r_peak_q;
	assign created_count   = r_made_q;
	assign destroyed_count = r_freed_q;
	assign pending_count   = r_pend_q;
	assign group_bytes     = r_group_q;
	assign record_handle   = r_handle_q;
	assign record_kind     = r_kind_q;

`ifndef SYNTHESIS
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CW'(TABLE_DEPTH)) else $error("live record count beyond table depth");
	a_mid_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit_mid |-> !ctrl.emit) else $error("leak beat collides with final beat");
`endif

endmodule
